/* hw/rtl/shd_pkg.sv */
// shared types, register indexes and constants of the spectral damper
package shd_pkg;

  localparam int unsigned NUM_MODES  = 4096;
  localparam int unsigned IDX_W      = $clog2(NUM_MODES);
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam logic [16:0] ONE_Q16    = 17'h10000;

  // item kinds
  localparam logic [1:0] KIND_APPLY = 2'd0;
  localparam logic [1:0] KIND_RELAX = 2'd1;
  localparam logic [1:0] KIND_SEED  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_VISC_EN    = 3'd0;
  localparam logic [2:0] REG_VISC_COEF  = 3'd1;
  localparam logic [2:0] REG_ORDER      = 3'd2;
  localparam logic [2:0] REG_CUTOFF     = 3'd3;
  localparam logic [2:0] REG_INV_BW     = 3'd4;
  localparam logic [2:0] REG_SFD_EN     = 3'd5;
  localparam logic [2:0] REG_SFD_STR    = 3'd6;
  localparam logic [2:0] REG_SFD_INV_TS = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   mode_index;
    logic [31:0]        k2;
    logic signed [31:0] state_re;
    logic signed [31:0] state_im;
    logic signed [31:0] rhs_re;
    logic signed [31:0] rhs_im;
    logic [31:0]        dt;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] rhs_out_re;
    logic signed [31:0] rhs_out_im;
    logic signed [31:0] filtered_re;
    logic signed [31:0] filtered_im;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SQRT,
    ST_RMUL,
    ST_RCLAMP,
    ST_POW_M,
    ST_POW_W,
    ST_WV_M,
    ST_WV_W,
    ST_WS_M,
    ST_WS_W,
    ST_TERM_M,
    ST_TERM_W,
    ST_ALPHA_M,
    ST_ALPHA_W,
    ST_RELAX_M,
    ST_RELAX_W,
    ST_WB,
    ST_DONE
  } state_e;

endpackage

/* hw/rtl/spectral_hyperviscosity_damper_top.sv */
// spectral hyperviscosity and selective frequency damping, filter store in block ram
// after reset a clearing pass zeroes the 4096-entry filter store, no words taken meanwhile
// one word at a time: apply runs the square root, then the power steps on the shared
//   multiplier, each a multiply and a write-back state, then four multiplies for terms
// relax, seed and other kinds take shorter paths from accept to result ready
// the next word is taken while a result still waits in the output register
module spectral_hyperviscosity_damper_top import shd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic        visc_en_q;
  logic [31:0] visc_coef_q;
  logic [4:0]  order_q;
  logic [31:0] cutoff_q;
  logic [31:0] inv_bw_q;
  logic        sfd_en_q;
  logic [31:0] sfd_str_q;
  logic [31:0] sfd_its_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_en_q   <= 1'b0;
      visc_coef_q <= '0;
      order_q     <= 5'd8;
      cutoff_q    <= '0;
      inv_bw_q    <= '0;
      sfd_en_q    <= 1'b0;
      sfd_str_q   <= '0;
      sfd_its_q   <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_VISC_EN:    visc_en_q   <= pwdata[0];
        REG_VISC_COEF:  visc_coef_q <= pwdata;
        REG_ORDER:      order_q     <= pwdata[4:0];
        REG_CUTOFF:     cutoff_q    <= pwdata;
        REG_INV_BW:     inv_bw_q    <= pwdata;
        REG_SFD_EN:     sfd_en_q    <= pwdata[0];
        REG_SFD_STR:    sfd_str_q   <= pwdata;
        REG_SFD_INV_TS: sfd_its_q   <= pwdata;
        default:        ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_VISC_EN:    prdata = {31'h0, visc_en_q};
      REG_VISC_COEF:  prdata = visc_coef_q;
      REG_ORDER:      prdata = {27'h0, order_q};
      REG_CUTOFF:     prdata = cutoff_q;
      REG_INV_BW:     prdata = inv_bw_q;
      REG_SFD_EN:     prdata = {31'h0, sfd_en_q};
      REG_SFD_STR:    prdata = sfd_str_q;
      REG_SFD_INV_TS: prdata = sfd_its_q;
      default:        prdata = '0;
    endcase
  end

  logic sfd_on;
  assign sfd_on = sfd_en_q & (sfd_str_q != '0);

  // filter store: {im, re}
  logic [63:0]      mem [NUM_MODES];
  logic [63:0]      rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [63:0]      mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[in_data_i.mode_index];
  end

  // control and datapath registers
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;
  in_word_t           item_q, item_d;
  logic signed [31:0] flt_q [2];
  logic signed [31:0] flt_d [2];
  logic signed [51:0] acc_q [2];
  logic signed [51:0] acc_d [2];
  logic [16:0]        r_q, r_d;
  logic [16:0]        p_q, p_d;
  logic [31:0]        wv_q, wv_d;
  logic [31:0]        ws_q, ws_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [1:0]         j_q, j_d;
  logic               sign_q, sign_d;
  logic [64:0]        prod_q;
  logic [31:0]        mul_a;
  logic [32:0]        mul_b;
  logic               sq_start;
  logic               sq_done;
  logic [23:0]        sq_root;

  shd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .k2_i    (item_q.k2),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // shared multiplier, registered product
  always_ff @(posedge clk_i) begin
    prod_q <= {33'h0, mul_a} * {32'h0, mul_b};
  end

  // operand of the current part: state alone or state minus filter
  logic               part;
  logic signed [31:0] st_part;
  logic signed [32:0] diff;
  logic signed [32:0] xval;
  logic [32:0]        xmag;
  logic [4:0]         n_eff;
  logic [48:0]        term;
  logic signed [33:0] flt_new;

  assign part    = j_q[0];
  assign st_part = part ? item_q.state_im : item_q.state_re;
  assign diff    = {st_part[31], st_part} - {flt_q[part][31], flt_q[part]};
  assign term    = prod_q[64:16];
  assign n_eff   = (order_q == 5'd0) ? 5'd1 : ((order_q > 5'd16) ? 5'd16 : order_q);

  always_comb begin
    if (state_q == ST_TERM_M && !j_q[1]) begin
      xval = {st_part[31], st_part};
    end else begin
      xval = diff;
    end
    xmag = xval[32] ? 33'(-xval) : 33'(xval);
  end

  assign flt_new = sign_q ? ({{2{flt_q[part][31]}}, flt_q[part]} - {1'b0, term[32:0]})
                          : ({{2{flt_q[part][31]}}, flt_q[part]} + {1'b0, term[32:0]});

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -52'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    item_d      = item_q;
    flt_d       = flt_q;
    acc_d       = acc_q;
    r_d         = r_q;
    p_d         = p_q;
    wv_d        = wv_q;
    ws_d        = ws_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    sign_d      = sign_q;
    mul_a       = '0;
    mul_b       = '0;
    sq_start    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = item_q.mode_index;
    mem_wdata   = {flt_q[1], flt_q[0]};
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(NUM_MODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        flt_d[0] = rdata_q[31:0];
        flt_d[1] = rdata_q[63:32];
        acc_d[0] = 52'(item_q.rhs_re);
        acc_d[1] = 52'(item_q.rhs_im);
        j_d      = '0;
        unique case (item_q.kind)
          KIND_APPLY: begin
            sq_start = 1'b1;
            state_d  = ST_SQRT;
          end
          KIND_RELAX: begin
            state_d = (sfd_on && sfd_its_q != '0 && item_q.dt != '0) ? ST_ALPHA_M : ST_DONE;
          end
          KIND_SEED: begin
            if (sfd_on) begin
              flt_d[0] = item_q.state_re;
              flt_d[1] = item_q.state_im;
              state_d  = ST_WB;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: begin
        mul_a   = inv_bw_q;
        mul_b   = ({8'h0, sq_root} > {1'b0, cutoff_q}) ? 33'({8'h0, sq_root} - {1'b0, cutoff_q})
                                                      : 33'h0;
        state_d = ST_RCLAMP;
      end
      ST_RCLAMP: begin
        r_d     = (term > 49'(ONE_Q16)) ? ONE_Q16 : term[16:0];
        p_d     = ONE_Q16;
        cnt_d   = n_eff;
        state_d = ST_POW_M;
      end
      ST_POW_M: begin
        mul_a   = {15'h0, p_q};
        mul_b   = {16'h0, r_q};
        state_d = ST_POW_W;
      end
      ST_POW_W: begin
        p_d     = prod_q[32:16];
        cnt_d   = cnt_q - 1'b1;
        state_d = (cnt_q == 5'd1) ? ST_WV_M : ST_POW_M;
      end
      ST_WV_M: begin
        mul_a   = visc_coef_q;
        mul_b   = {16'h0, p_q};
        state_d = ST_WV_W;
      end
      ST_WV_W: begin
        wv_d    = (visc_en_q && visc_coef_q != '0) ? prod_q[47:16] : 32'h0;
        state_d = ST_WS_M;
      end
      ST_WS_M: begin
        mul_a   = sfd_str_q;
        mul_b   = {16'h0, p_q};
        state_d = ST_WS_W;
      end
      ST_WS_W: begin
        ws_d    = sfd_on ? prod_q[47:16] : 32'h0;
        j_d     = '0;
        state_d = ST_TERM_M;
      end
      // terms: visc re, visc im, sfd re, sfd im
      ST_TERM_M: begin
        mul_a   = j_q[1] ? ws_q : wv_q;
        mul_b   = xmag;
        sign_d  = xval[32];
        state_d = ST_TERM_W;
      end
      ST_TERM_W: begin
        acc_d[part] = sign_q ? (acc_q[part] + {3'b000, term})
                             : (acc_q[part] - {3'b000, term});
        j_d         = j_q + 1'b1;
        state_d     = (j_q == 2'd3) ? ST_DONE : ST_TERM_M;
      end
      ST_ALPHA_M: begin
        mul_a   = item_q.dt;
        mul_b   = {1'b0, sfd_its_q};
        state_d = ST_ALPHA_W;
      end
      ST_ALPHA_W: begin
        r_d     = (term > 49'(ONE_Q16)) ? ONE_Q16 : term[16:0];
        j_d     = '0;
        state_d = ST_RELAX_M;
      end
      ST_RELAX_M: begin
        mul_a   = {15'h0, r_q};
        mul_b   = xmag;
        sign_d  = xval[32];
        state_d = ST_RELAX_W;
      end
      ST_RELAX_W: begin
        flt_d[part] = flt_new[31:0];
        j_d         = j_q + 1'b1;
        state_d     = (j_q == 2'd1) ? ST_WB : ST_RELAX_M;
      end
      ST_WB: begin
        mem_we  = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          for (int i = 0; i < 2; i++) begin
            if (acc_q[i] > 52'sd2147483647) begin
              flt_d[i] = flt_q[i];
            end
          end
          out_d.rhs_out_re  = sat32(acc_q[0]);
          out_d.rhs_out_im  = sat32(acc_q[1]);
          out_d.filtered_re = flt_q[0];
          out_d.filtered_im = flt_q[1];
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    item_q <= item_d;
    flt_q  <= flt_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    p_q    <= p_d;
    wv_q   <= wv_d;
    ws_q   <= ws_d;
    sign_q <= sign_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ))
    else $error("accepted word did not start a store read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQRT))
    else $error("square root finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_o && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwrote a word still waiting at the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POW_M) |-> (r_q <= ONE_Q16 && p_q <= ONE_Q16))
    else $error("ratio or power above one");

endmodule

/* hw/rtl/shd_isqrt.sv */
// iterative integer square root of k2 in q16.16, one result bit per cycle
module shd_isqrt import shd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] k2_i,
  output logic        done_o,
  output logic [23:0] root_o
);

  logic [47:0]           v_q, v_d;
  logic [26:0]           rem_q, rem_d;
  logic [23:0]           root_q, root_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [26:0]           rem_pre;
  logic [26:0]           trial;

  // one restoring step per cycle
  always_comb begin
    rem_pre = {rem_q[24:0], v_q[47:46]};
    trial   = {1'b0, root_q, 2'b01};
    v_d     = v_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      v_d    = {k2_i, 16'h0000};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = {v_q[45:0], 2'b00};
      if (rem_pre >= trial) begin
        rem_d  = rem_pre - trial;
        root_d = {root_q[22:0], 1'b1};
      end else begin
        rem_d  = rem_pre;
        root_d = {root_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
